FILE: hw/rtl/c1d_pkg.sv
// ----------------------------------------------------------------------------
// c1d_pkg
// Shared types, codes and constants of the strided, dilated 1-D convolution.
// ----------------------------------------------------------------------------
package c1d_pkg;

  // default store bounds
  localparam int DefMaxInCh  = 16;
  localparam int DefMaxOutCh = 16;
  localparam int DefMaxTaps  = 16;
  localparam int DefMaxLen   = 256;

  // configuration register indexes
  localparam logic [2:0] CFG_IN_CH    = 3'd0;
  localparam logic [2:0] CFG_OUT_CH   = 3'd1;
  localparam logic [2:0] CFG_KSIZE    = 3'd2;
  localparam logic [2:0] CFG_STRIDE   = 3'd3;
  localparam logic [2:0] CFG_PADDING  = 3'd4;
  localparam logic [2:0] CFG_DILATION = 3'd5;
  localparam logic [2:0] CFG_USE_BIAS = 3'd6;
  localparam logic [2:0] CFG_IN_LEN   = 3'd7;

  localparam int CfgDataW = 9;
  localparam int CfgIdxW  = 3;

  typedef enum logic [1:0] {
    OP_LOAD_W  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_S  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [3:0]          out_ch;
    logic [3:0]          in_ch;
    logic [7:0]          pos;
    logic signed [15:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          res_ch;
    logic [7:0]          res_pos;
    logic signed [31:0]  conv_result;
    logic                out_of_range;
  } out_item_t;

  function automatic int addr_width(input int depth);
    addr_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: hw/rtl/conv1d_strided_dilated.sv
// ----------------------------------------------------------------------------
// conv1d_strided_dilated
// One-dimensional multi-channel convolution with stride, padding and dilation.
// ----------------------------------------------------------------------------
// Weight, bias and sample loads are taken while idle and give no result.
// A compute request runs a check state, then one tap per cycle (one read of the
// weight RAM and one of the sample RAM, which sets the rate), then drains the
// RAM read and product registers of the pipeline and saturates the sum;
// res_valid_o pulses in the first cycle with busy low again. A request that
// names no valid output is busy only for the check and its flagged zero result
// follows at once. Results are shown for exactly one cycle and cannot be held
// off by the receiver. The stores need no clearing after reset; entries must be
// written before a compute reads them.
module conv1d_strided_dilated
  import c1d_pkg::*;
#(
  parameter int MAX_IN_CH  = DefMaxInCh,
  parameter int MAX_OUT_CH = DefMaxOutCh,
  parameter int MAX_TAPS   = DefMaxTaps,
  parameter int MAX_LEN    = DefMaxLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  input  in_item_t            item_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output out_item_t           result_o
);

  localparam int WDepth = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
  localparam int SDepth = MAX_IN_CH * MAX_LEN;
  localparam int WAW    = addr_width(WDepth);
  localparam int SAW    = addr_width(SDepth);
  localparam int BAW    = addr_width(MAX_OUT_CH);
  localparam int TapW   = 16;
  localparam int AccW   = 40;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SAT   = 3'd4;

  // configuration registers
  logic [4:0] cfg_in_ch_q, cfg_out_ch_q, cfg_ks_q, cfg_stride_q, cfg_dil_q;
  logic [3:0] cfg_pad_q;
  logic       cfg_bias_q;
  logic [8:0] cfg_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_ch_q  <= 5'd1;
      cfg_out_ch_q <= 5'd1;
      cfg_ks_q     <= 5'd1;
      cfg_stride_q <= 5'd1;
      cfg_pad_q    <= 4'd0;
      cfg_dil_q    <= 5'd1;
      cfg_bias_q   <= 1'b0;
      cfg_len_q    <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_CH:    cfg_in_ch_q  <= cfg_data_i[4:0];
        CFG_OUT_CH:   cfg_out_ch_q <= cfg_data_i[4:0];
        CFG_KSIZE:    cfg_ks_q     <= cfg_data_i[4:0];
        CFG_STRIDE:   cfg_stride_q <= cfg_data_i[4:0];
        CFG_PADDING:  cfg_pad_q    <= cfg_data_i[3:0];
        CFG_DILATION: cfg_dil_q    <= cfg_data_i[4:0];
        CFG_USE_BIAS: cfg_bias_q   <= cfg_data_i[0];
        CFG_IN_LEN:   cfg_len_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]     state_q, state_d;
  logic [3:0]     req_oc_q;
  logic [7:0]     req_pos_q;
  logic [4:0]     ic_q, ic_d, k_q, k_d;
  logic signed [TapW-1:0] tap_q, tap_d, tap_base_q, tap_base_d;
  logic [WAW-1:0] w_row_q, w_row_d;
  logic [SAW-1:0] s_row_q, s_row_d;
  logic           drain_q, drain_d;
  logic           iss_vld_q, iss_vld_d;
  logic           prod_vld_q;
  logic signed [31:0]     prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic           res_valid_q, res_valid_d;
  out_item_t      result_q, result_d;

  logic accept, load_w, load_b, load_s, compute_req;
  assign accept      = start_i && (state_q == S_IDLE);
  assign load_w      = accept && (item_i.op == OP_LOAD_W) && (int'(item_i.out_ch) < MAX_OUT_CH)
                       && (int'(item_i.in_ch) < MAX_IN_CH) && (int'(item_i.pos) < MAX_TAPS);
  assign load_b      = accept && (item_i.op == OP_LOAD_B) && (int'(item_i.out_ch) < MAX_OUT_CH);
  assign load_s      = accept && (item_i.op == OP_LOAD_S) && (int'(item_i.in_ch) < MAX_IN_CH)
                       && (int'(item_i.pos) < MAX_LEN);
  assign compute_req = accept && (item_i.op == OP_COMPUTE);

  // stores
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [BAW-1:0] b_addr;
  logic [15:0]    w_rdata, s_rdata, b_rdata;

  assign w_waddr = WAW'((int'(item_i.out_ch) * MAX_IN_CH + int'(item_i.in_ch)) * MAX_TAPS
                        + int'(item_i.pos));
  assign s_waddr = SAW'(int'(item_i.in_ch) * MAX_LEN + int'(item_i.pos));
  assign b_addr  = (state_q == S_IDLE) ? BAW'(item_i.out_ch) : BAW'(req_oc_q);
  assign w_raddr = w_row_q + WAW'(k_q);
  assign s_raddr = s_row_q + SAW'($unsigned(tap_q));

  c1d_ram #(.Width(16), .Depth(WDepth)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (load_w),
    .waddr_i (w_waddr),
    .wdata_i (item_i.value),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  c1d_ram #(.Width(16), .Depth(MAX_OUT_CH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (load_b),
    .waddr_i (b_addr),
    .wdata_i (item_i.value),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  c1d_ram #(.Width(16), .Depth(SDepth)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (load_s),
    .waddr_i (s_waddr),
    .wdata_i (item_i.value),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // request check: pos < output length  <=>  pos * stride + span <= padded
  logic [9:0]  dil_x_k;
  logic [10:0] span, padded;
  logic [12:0] pos_x_stride;
  logic        cfg_ok, req_ok, tap_in;

  assign dil_x_k      = 10'(cfg_dil_q) * (10'(cfg_ks_q) - 10'd1);
  assign span         = 11'(dil_x_k) + 11'd1;
  assign padded       = 11'(cfg_len_q) + {6'd0, cfg_pad_q, 1'b0};
  assign pos_x_stride = 13'(req_pos_q) * 13'(cfg_stride_q);

  assign cfg_ok = (cfg_in_ch_q != 5'd0) && (int'(cfg_in_ch_q) <= MAX_IN_CH)
               && (cfg_out_ch_q != 5'd0) && (int'(cfg_out_ch_q) <= MAX_OUT_CH)
               && (cfg_ks_q != 5'd0) && (int'(cfg_ks_q) <= MAX_TAPS)
               && (cfg_stride_q != 5'd0) && (cfg_dil_q != 5'd0)
               && (cfg_len_q != 9'd0) && (int'(cfg_len_q) <= MAX_LEN)
               && (span <= padded);
  assign req_ok = cfg_ok && ({1'b0, req_oc_q} < cfg_out_ch_q)
               && ((14'(pos_x_stride) + 14'(span)) <= 14'(padded));

  assign tap_base_d = $signed(TapW'(pos_x_stride)) - $signed(TapW'(cfg_pad_q));
  assign tap_in     = !tap_q[TapW-1] && (tap_q[TapW-2:0] < (TapW-1)'(cfg_len_q));

  // saturation of the final sum
  logic signed [31:0] sat;
  always_comb begin
    if (acc_q[AccW-1:31] == {(AccW-31){1'b0}} || acc_q[AccW-1:31] == {(AccW-31){1'b1}}) begin
      sat = acc_q[31:0];
    end else if (acc_q[AccW-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    state_d     = state_q;
    ic_d        = ic_q;
    k_d         = k_q;
    tap_d       = tap_q;
    w_row_d     = w_row_q;
    s_row_d     = s_row_q;
    drain_d     = drain_q;
    iss_vld_d   = 1'b0;
    acc_d       = acc_q;
    res_valid_d = 1'b0;
    result_d    = result_q;
    if (prod_vld_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
    case (state_q)
      S_IDLE: begin
        if (compute_req) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        acc_d   = cfg_bias_q ? {{(AccW-24){b_rdata[15]}}, b_rdata, 8'd0} : '0;
        ic_d    = 5'd0;
        k_d     = 5'd0;
        tap_d   = tap_base_d;
        w_row_d = WAW'(int'(req_oc_q) * (MAX_IN_CH * MAX_TAPS));
        s_row_d = '0;
        if (req_ok) begin
          state_d = S_RUN;
        end else begin
          state_d                  = S_IDLE;
          res_valid_d              = 1'b1;
          result_d.res_ch          = req_oc_q;
          result_d.res_pos         = req_pos_q;
          result_d.conv_result     = '0;
          result_d.out_of_range    = 1'b1;
        end
      end
      S_RUN: begin
        iss_vld_d = tap_in;
        if (k_q == cfg_ks_q - 5'd1) begin
          k_d     = 5'd0;
          tap_d   = tap_base_q;
          ic_d    = ic_q + 5'd1;
          w_row_d = w_row_q + WAW'(MAX_TAPS);
          s_row_d = s_row_q + SAW'(MAX_LEN);
          if (ic_q == cfg_in_ch_q - 5'd1) begin
            state_d = S_DRAIN;
            drain_d = 1'b0;
          end
        end else begin
          k_d   = k_q + 5'd1;
          tap_d = tap_q + $signed(TapW'(cfg_dil_q));
        end
      end
      S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        state_d               = S_IDLE;
        res_valid_d           = 1'b1;
        result_d.res_ch       = req_oc_q;
        result_d.res_pos      = req_pos_q;
        result_d.conv_result  = sat;
        result_d.out_of_range = 1'b0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_vld_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
      drain_q     <= 1'b0;
      ic_q        <= 5'd0;
      k_q         <= 5'd0;
    end else begin
      state_q     <= state_d;
      iss_vld_q   <= iss_vld_d;
      prod_vld_q  <= iss_vld_q;
      res_valid_q <= res_valid_d;
      drain_q     <= drain_d;
      ic_q        <= ic_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (compute_req) begin
      req_oc_q  <= item_i.out_ch;
      req_pos_q <= item_i.pos;
    end
    if (state_q == S_CHECK) begin
      tap_base_q <= tap_base_d;
    end
    tap_q    <= tap_d;
    w_row_q  <= w_row_d;
    s_row_q  <= s_row_d;
    prod_q   <= 32'($signed(w_rdata)) * 32'($signed(s_rdata));
    acc_q    <= acc_d;
    result_q <= result_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign result_o    = result_q;

  // a compute transaction always leaves idle in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    compute_req |=> (state_q == S_CHECK))
    else $error("compute transaction did not start the check");

  // loads never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !compute_req) |=> !res_valid_o)
    else $error("load transaction produced a result");

  // results only appear once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == S_IDLE))
    else $error("result shown while still busy");

  // flagged results carry a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.out_of_range) |-> (result_o.conv_result == 32'sd0))
    else $error("flagged result with nonzero sum");

  // the tap and channel counters stay inside the kernel while issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (k_q < cfg_ks_q && ic_q < cfg_in_ch_q))
    else $error("tap walk left the kernel");

endmodule

FILE: hw/rtl/c1d_ram.sv
// ----------------------------------------------------------------------------
// c1d_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module c1d_ram
  import c1d_pkg::*;
#(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = addr_width(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
